@@ hw/rtl/rgbhsl_pkg.sv @@
// ---------------------------------------------------------------------------
// rgbhsl_pkg
// Shared constants, pipeline types and divider step functions for the
// RGB to HSL converter.
// ---------------------------------------------------------------------------
`default_nettype none

package rgbhsl_pkg;

    // Fractional bits of the fine hue and of the fine saturation/lightness
    localparam int HUE_FRAC_BITS   = 6;
    localparam int LEVEL_FRAC_BITS = 12;

    // Pixel component, component sum and divider remainder widths
    localparam int PIX_W = 8;
    localparam int SUM_W = 9;
    localparam int REM_W = 9;

    // Six times the hue in units of the chroma: below 6 * 255
    localparam int H6_W = 11;

    // Quotient bits: hue below 360 degrees, levels up to and including one
    localparam int HUE_QW    = $clog2(360 * (2 ** HUE_FRAC_BITS));
    localparam int LEVEL_QW  = LEVEL_FRAC_BITS + 1;
    localparam int DIV_STEPS = (HUE_QW > LEVEL_QW) ? HUE_QW : LEVEL_QW;
    localparam int NUM_W     = REM_W + DIV_STEPS;

    // Index of the last stage before the output register
    localparam int PIPE_LAST = DIV_STEPS + 1;

    // Half of one degree in fine hue units (zero when there is no fraction)
    localparam int HUE_HALF = (2 ** HUE_FRAC_BITS) / 2;

    // Divider lanes
    localparam int LANE_HUE      = 0;
    localparam int LANE_SAT_PCT  = 1;
    localparam int LANE_SAT_FINE = 2;
    localparam int NUM_LANES     = 3;

    localparam logic [NUM_W-1:0] HUE_SCALE = NUM_W'(60 * (2 ** HUE_FRAC_BITS));
    localparam logic [NUM_W-1:0] PCT_SCALE = NUM_W'(100);
    localparam logic [REM_W-1:0] LIGHT_DEN = REM_W'(510);
    localparam logic [SUM_W-1:0] SUM_HALF  = SUM_W'(255);

    // Lightness by reciprocal multiply:
    //   percent = floor((20 * sum + 51) / 102)
    //   fine    = floor((sum * 2^LEVEL_FRAC_BITS + 255) / 510)
    // The reciprocals are rounded up, with enough shift that the error
    // never reaches the next integer over the whole sum range.
    localparam int     LIGHT_PCT_QW     = 7;
    localparam int     LIGHT_PCT_SHIFT  = 21;
    localparam longint LIGHT_PCT_RECIP  = ((longint'(1) << LIGHT_PCT_SHIFT) + 101) / 102;
    localparam int     LIGHT_PCT_W      = LIGHT_PCT_SHIFT + LIGHT_PCT_QW;
    localparam int     LIGHT_FINE_SHIFT = LEVEL_FRAC_BITS + 19;
    localparam longint LIGHT_FINE_RECIP = ((longint'(1) << LIGHT_FINE_SHIFT) + 509) / 510;
    localparam int     LIGHT_FINE_W     = LIGHT_FINE_SHIFT + LEVEL_QW;

    localparam logic [LIGHT_PCT_W-1:0]  LIGHT_PCT_SCALE  =
        LIGHT_PCT_W'(20 * LIGHT_PCT_RECIP);
    localparam logic [LIGHT_PCT_W-1:0]  LIGHT_PCT_BIAS   =
        LIGHT_PCT_W'(51 * LIGHT_PCT_RECIP);
    localparam logic [LIGHT_FINE_W-1:0] LIGHT_FINE_SCALE =
        LIGHT_FINE_W'(LIGHT_FINE_RECIP << LEVEL_FRAC_BITS);
    localparam logic [LIGHT_FINE_W-1:0] LIGHT_FINE_BIAS  =
        LIGHT_FINE_W'(255 * LIGHT_FINE_RECIP);

    // Sector of the largest component; red splits on the hue wrap
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_RED_WRAP,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [PIX_W-1:0]        chroma;
        logic [SUM_W-1:0]        sum;
        logic signed [SUM_W-1:0] diff;
        sector_t                 sector;
    } prep_t;

    // One restoring divider lane: partial remainder, numerator bits that
    // shift out while quotient bits shift in, and the divisor
    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] quo;
        logic [REM_W-1:0]     den;
    } lane_t;

    // Divider lanes plus the finished lightness riding alongside
    typedef struct packed {
        lane_t [NUM_LANES-1:0]   lane;
        logic [LIGHT_PCT_QW-1:0] light_pct;
        logic [LEVEL_QW-1:0]     light_fine;
        logic                    gray;
    } div_stage_t;

    // Load a lane: the numerator is below den * 2^DIV_STEPS
    function automatic lane_t lane_load(logic [NUM_W-1:0] num, logic [REM_W-1:0] den);
        lane_t l;
        l.rem = num[NUM_W-1 -: REM_W];
        l.quo = num[DIV_STEPS-1:0];
        l.den = den;
        return l;
    endfunction

    // One quotient bit: shift in the next numerator bit, subtract if it fits
    function automatic lane_t lane_step(lane_t l_in);
        lane_t          l;
        logic [REM_W:0] trial;
        logic [REM_W:0] den_ext;
        l       = l_in;
        trial   = {l_in.rem, l_in.quo[DIV_STEPS-1]};
        den_ext = {1'b0, l_in.den};
        if (trial >= den_ext)
        begin
            l.rem = REM_W'(trial - den_ext);
            l.quo = {l_in.quo[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            l.rem = trial[REM_W-1:0];
            l.quo = {l_in.quo[DIV_STEPS-2:0], 1'b0};
        end
        return l;
    endfunction

    function automatic div_stage_t div_stage_step(div_stage_t s_in);
        div_stage_t s;
        s = s_in;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            s.lane[i] = lane_step(s_in.lane[i]);
        end
        return s;
    endfunction

    // Round half up: add one when twice the remainder reaches the divisor
    function automatic logic [DIV_STEPS:0] lane_round(lane_t l);
        logic up;
        up = ({l.rem, 1'b0} >= {1'b0, l.den});
        return (DIV_STEPS + 1)'(l.quo) + (DIV_STEPS + 1)'(up);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rgb_to_hsl_converter.sv @@
// ---------------------------------------------------------------------------
// rgb_to_hsl_converter
// Pipelined RGB to HSL conversion with coarse and fine rounded outputs.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one 8-bit RGB pixel per
//   request; output channel (out_valid/out_ready) carries hue, saturation
//   and lightness, each in whole degrees/percent and in fine fixed point.
//   Throughput: one pixel per clock while the receiver takes results.
//   From acceptance to out_valid a pixel passes a min/max stage, a
//   numerator stage, the restoring divider (15 quotient bits with 6 fine
//   hue bits), which resolves one quotient bit per stage in three
//   parallel lanes (hue, two saturations), and the rounding output
//   register. Lightness comes from a reciprocal multiply in the numerator
//   stage and rides beside the lanes.
//   Reset clears every stage valid bit and the output valid; no pixel
//   survives reset.
//   A stall on the output holds the result register. The pipeline keeps
//   moving, and in_ready stays high, until a pixel reaches the last stage
//   with nowhere to go; then all stages hold together. Nothing is dropped
//   or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [8:0]       hue_degrees,
    output logic [6:0]       saturation_percent,
    output logic [6:0]       lightness_percent,
    output logic [14:0]      hue_fine,
    output logic [12:0]      saturation_fine,
    output logic [12:0]      lightness_fine
);

    // Pipeline control
    logic [PIPE_LAST:0] pipe_vld_reg;
    logic               advance;
    logic               out_load;

    // Stage A: min/max and sector
    prep_t              prep_reg;
    prep_t              prep_next;
    logic [PIX_W-1:0]   comp_max;
    logic [PIX_W-1:0]   comp_min;

    // Stage B and divider stages
    div_stage_t         div_reg  [DIV_STEPS+1];
    div_stage_t         div_next [DIV_STEPS+1];
    logic [H6_W-1:0]    chroma_mult;
    logic signed [H6_W:0] h6_sum;
    logic [H6_W-1:0]    h6;
    logic [REM_W-1:0]   sat_den;
    logic [LIGHT_PCT_W-1:0]  light_pct_prod;
    logic [LIGHT_FINE_W-1:0] light_fine_prod;

    // Rounding
    logic [DIV_STEPS:0] hue_round;
    logic [DIV_STEPS:0] hue_coarse;
    logic [DIV_STEPS:0] sat_pct_round;
    logic [DIV_STEPS:0] sat_fine_round;

    // Output register
    logic               out_valid_reg;
    logic [8:0]         hue_degrees_reg;
    logic [6:0]         saturation_percent_reg;
    logic [6:0]         lightness_percent_reg;
    logic [14:0]        hue_fine_reg;
    logic [12:0]        saturation_fine_reg;
    logic [12:0]        lightness_fine_reg;
    logic [8:0]         hue_degrees_next;
    logic [6:0]         saturation_percent_next;
    logic [6:0]         lightness_percent_next;
    logic [14:0]        hue_fine_next;
    logic [12:0]        saturation_fine_next;
    logic [12:0]        lightness_fine_next;

    // Advance the pipeline unless a request sits in the last stage while
    // the output register is full and stalled
    assign advance  = out_ready || !out_valid_reg || !pipe_vld_reg[PIPE_LAST];
    assign out_load = out_ready || !out_valid_reg;
    assign in_ready = advance;

    // Stage A: pick the largest component, tie order red, green, blue
    always_comb
    begin
        prep_next = '0;
        if ((red >= green) && (red >= blue))
        begin
            comp_max         = red;
            prep_next.sector = (green < blue) ? SECT_RED_WRAP : SECT_RED;
            prep_next.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            comp_max         = green;
            prep_next.sector = SECT_GREEN;
            prep_next.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            comp_max         = blue;
            prep_next.sector = SECT_BLUE;
            prep_next.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end

        comp_min = red;
        if (green < comp_min)
        begin
            comp_min = green;
        end
        if (blue < comp_min)
        begin
            comp_min = blue;
        end

        prep_next.chroma = comp_max - comp_min;
        prep_next.sum    = SUM_W'(comp_max) + SUM_W'(comp_min);
    end

    // Stage B: build numerators and divisors; then one quotient bit a stage
    always_comb
    begin
        case (prep_reg.sector)
            SECT_RED:      chroma_mult = '0;
            SECT_RED_WRAP: chroma_mult = (H6_W'(prep_reg.chroma) << 2)
                                       + (H6_W'(prep_reg.chroma) << 1);
            SECT_GREEN:    chroma_mult = H6_W'(prep_reg.chroma) << 1;
            SECT_BLUE:     chroma_mult = H6_W'(prep_reg.chroma) << 2;
            default:       chroma_mult = '0;
        endcase

        // Hue times chroma over 60, always in [0, 6 * chroma)
        h6_sum = $signed({1'b0, chroma_mult}) + (H6_W + 1)'(prep_reg.diff);
        h6     = h6_sum[H6_W-1:0];

        // Saturation divisor is min(sum, 510 - sum)
        sat_den = (prep_reg.sum <= SUM_HALF) ? prep_reg.sum : LIGHT_DEN - prep_reg.sum;

        // Lightness by reciprocal multiply; the quotient is the top bits
        light_pct_prod  = LIGHT_PCT_W'(prep_reg.sum) * LIGHT_PCT_SCALE + LIGHT_PCT_BIAS;
        light_fine_prod = LIGHT_FINE_W'(prep_reg.sum) * LIGHT_FINE_SCALE + LIGHT_FINE_BIAS;

        div_next[0].gray       = (prep_reg.chroma == '0);
        div_next[0].light_pct  = light_pct_prod[LIGHT_PCT_W-1 -: LIGHT_PCT_QW];
        div_next[0].light_fine = light_fine_prod[LIGHT_FINE_W-1 -: LEVEL_QW];
        div_next[0].lane[LANE_HUE] =
            lane_load(NUM_W'(h6) * HUE_SCALE, REM_W'(prep_reg.chroma));
        div_next[0].lane[LANE_SAT_PCT] =
            lane_load(NUM_W'(prep_reg.chroma) * PCT_SCALE, sat_den);
        div_next[0].lane[LANE_SAT_FINE] =
            lane_load(NUM_W'(prep_reg.chroma) << LEVEL_FRAC_BITS, sat_den);

        for (int i = 0; i < DIV_STEPS; i++)
        begin
            div_next[i+1] = div_stage_step(div_reg[i]);
        end
    end

    // Round the finished quotients; grey pixels have no hue or saturation
    always_comb
    begin
        hue_round        = lane_round(div_reg[DIV_STEPS].lane[LANE_HUE]);
        sat_pct_round    = lane_round(div_reg[DIV_STEPS].lane[LANE_SAT_PCT]);
        sat_fine_round   = lane_round(div_reg[DIV_STEPS].lane[LANE_SAT_FINE]);

        // Whole degrees from the fine quotient: the dropped remainder can
        // never carry across a whole-degree boundary
        if (HUE_FRAC_BITS == 0)
        begin
            hue_coarse = hue_round;
        end
        else
        begin
            hue_coarse = ((DIV_STEPS + 1)'(div_reg[DIV_STEPS].lane[LANE_HUE].quo)
                         + (DIV_STEPS + 1)'(HUE_HALF)) >> HUE_FRAC_BITS;
        end

        hue_degrees_next        = 9'(hue_coarse);
        hue_fine_next           = 15'(hue_round);
        saturation_percent_next = 7'(sat_pct_round);
        saturation_fine_next    = 13'(sat_fine_round);
        lightness_percent_next  = 7'(div_reg[DIV_STEPS].light_pct);
        lightness_fine_next     = 13'(div_reg[DIV_STEPS].light_fine);

        if (div_reg[DIV_STEPS].gray)
        begin
            hue_degrees_next        = '0;
            hue_fine_next           = '0;
            saturation_percent_next = '0;
            saturation_fine_next    = '0;
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                pipe_vld_reg <= {pipe_vld_reg[PIPE_LAST-1:0], in_valid};
            end
            if (out_load)
            begin
                out_valid_reg <= pipe_vld_reg[PIPE_LAST];
            end
        end
    end

    // Pipeline payload, held on stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_reg <= prep_next;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                div_reg[i] <= div_next[i];
            end
        end
        if (out_load)
        begin
            hue_degrees_reg        <= hue_degrees_next;
            saturation_percent_reg <= saturation_percent_next;
            lightness_percent_reg  <= lightness_percent_next;
            hue_fine_reg           <= hue_fine_next;
            saturation_fine_reg    <= saturation_fine_next;
            lightness_fine_reg     <= lightness_fine_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign hue_degrees        = hue_degrees_reg;
    assign saturation_percent = saturation_percent_reg;
    assign lightness_percent  = lightness_percent_reg;
    assign hue_fine           = hue_fine_reg;
    assign saturation_fine    = saturation_fine_reg;
    assign lightness_fine     = lightness_fine_reg;

    // A request in the last stage is kept while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_vld_reg[PIPE_LAST] && out_valid && !out_ready) |=> pipe_vld_reg[PIPE_LAST])
    else $error("last stage request lost during output stall");

    // Results stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hue_degrees <= 9'd360) && (saturation_percent <= 7'd100)
                      && (lightness_percent <= 7'd100)
                      && (saturation_fine <= 13'd4096) && (lightness_fine <= 13'd4096))
    else $error("result out of range");

    // A pixel with nonzero fine hue always has nonzero saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (hue_fine != 15'd0)) |-> (saturation_fine != 13'd0))
    else $error("hue without saturation");

endmodule

`default_nettype wire
